// ===== hw/rtl/cursor_doubly_linked_list_macros.svh =====
// ----------------------------------------------------------------------------
// Cursor doubly linked list assertion macros
// Immediate-implication and next-cycle checks on the clock, gated by reset.
// ----------------------------------------------------------------------------
`ifndef CURSOR_DOUBLY_LINKED_LIST_MACROS_SVH
`define CURSOR_DOUBLY_LINKED_LIST_MACROS_SVH

// check c in the same cycle whenever a holds
`define CDLL_ASSERT_NOW(label, a, c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error(msg);

// check c in the cycle after a holds
`define CDLL_ASSERT_NEXT(label, a, c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error(msg);

`endif

// ===== hw/rtl/cdll_pkg.sv =====
// ----------------------------------------------------------------------------
// Cursor doubly linked list package
// Shared constants, action and status codes, and the control state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cdll_pkg;

   localparam int CAPACITY_DEF   = 256;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int ACTION_W       = 4;
   localparam int STATUS_W       = 2;
   localparam int ENTRY_W        = 9;

   localparam logic [ACTION_W-1:0] ACT_PREPEND      = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND       = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT_PREV  = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_INSERT_NEXT  = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_CUR   = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_FIRST = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_LAST  = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_CURSOR_PREV  = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_CURSOR_NEXT  = 4'd8;
   localparam logic [ACTION_W-1:0] ACT_READ         = 4'd9;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_POPWAIT,
      ST_LINK,
      ST_RDWAIT,
      ST_APPLY,
      ST_FIX
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cdll_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one action and its data word per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdll_req_if
   import cdll_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [DATA_WIDTH-1:0] data_in;

   modport source (output valid, action, data_in, input ready);
   modport sink   (input valid, action, data_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cdll_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result beat per action.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdll_rsp_if
   import cdll_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] data_out;
   logic [STATUS_W-1:0]   status;
   logic [ENTRY_W-1:0]    entry_count;

   modport source (output valid, data_out, status, entry_count, input ready);
   modport sink   (input valid, data_out, status, entry_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cdll_ram.sv =====
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdll_ram
   import cdll_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

`default_nettype wire

// ===== hw/rtl/cursor_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// Cursor doubly linked list
// Fixed-capacity doubly linked list with a cursor, node pool and free stack.
// ----------------------------------------------------------------------------
//   channel   dir   beat
//   req_chan  in    action, data_in
//   rsp_chan  out   data_out, status, entry_count
//
// One action at a time; each action steps from accept to result through the
// dependent reads and writes of the link memories (registered read, one
// write each); a pop from a previously used stack slot adds a wait state.
// Reset is synchronous; the free stack needs no clearing pass, untouched
// stack slots are tracked by a low-water mark.
// A result waits in the output register; a new action is taken meanwhile
// but holds in its first step until that register is free.
`default_nettype none

module cursor_doubly_linked_list
   import cdll_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   cdll_req_if.sink   req_chan,
   cdll_rsp_if.source rsp_chan
);
   localparam int IDX_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] NIL  = IDX_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);
   localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);
   localparam logic [IDX_W:0]   POOL_SIZE = (IDX_W + 1)'(CAPACITY);

   state_type state_ff, state_in;
   logic [ACTION_W-1:0]   act_ff, act_in;
   logic [DATA_WIDTH-1:0] din_ff, din_in;
   logic [IDX_W-1:0]      node_ff, node_in;
   logic [IDX_W-1:0]      p_ff, p_in, q_ff, q_in;
   logic [DATA_WIDTH-1:0] w_ff, w_in;
   logic [IDX_W-1:0]      head_ff, head_in, tail_ff, tail_in, cursor_ff, cursor_in;
   logic [IDX_W-1:0]      count_ff, count_in, free_top_ff, free_top_in, wm_ff, wm_in;
   logic                  out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic [STATUS_W-1:0]   out_status_ff, out_status_in;
   logic [ENTRY_W-1:0]    out_count_ff, out_count_in;

   logic                  data_we, next_we, prev_we, free_we;
   logic [ADDR_W-1:0]     data_wa, next_wa, prev_wa, free_wa;
   logic [ADDR_W-1:0]     data_ra, next_ra, prev_ra, free_ra;
   logic [DATA_WIDTH-1:0] data_wd, data_rd;
   logic [IDX_W-1:0]      next_wd, prev_wd, next_rd, prev_rd;
   logic [ADDR_W-1:0]     free_wd, free_rd;

   logic                  is_ins, is_rem, start_fail, pop_fresh, out_free;
   logic [IDX_W-1:0]      pop_pos, sel_node, rem_head, rem_tail, rem_count;
   logic                  fin;
   logic [DATA_WIDTH-1:0] fin_data;
   logic [STATUS_W-1:0]   fin_status;

   logic [IDX_W:0]        pool_total;
   logic                  cursor_ok;

   cdll_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_WIDTH)) u_data (
      .clock(clock), .wr_en(data_we), .wr_addr(data_wa), .wr_data(data_wd),
      .rd_addr(data_ra), .rd_data(data_rd));
   cdll_ram #(.DEPTH(CAPACITY), .WIDTH(IDX_W)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(next_ra), .rd_data(next_rd));
   cdll_ram #(.DEPTH(CAPACITY), .WIDTH(IDX_W)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(prev_ra), .rd_data(prev_rd));
   cdll_ram #(.DEPTH(CAPACITY), .WIDTH(ADDR_W)) u_free (
      .clock(clock), .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(free_ra), .rd_data(free_rd));

   always_comb begin
      is_ins   = (act_ff <= ACT_INSERT_NEXT);
      is_rem   = (act_ff >= ACT_REMOVE_CUR) && (act_ff <= ACT_REMOVE_LAST);
      pop_pos  = free_top_ff - ONE;
      pop_fresh = (pop_pos < wm_ff);
      out_free = !out_valid_ff || rsp_chan.ready;
      case (act_ff)
         ACT_REMOVE_CUR:   sel_node = cursor_ff;
         ACT_REMOVE_FIRST: sel_node = head_ff;
         default:          sel_node = tail_ff;
      endcase
      case (act_ff) inside
         ACT_PREPEND, ACT_APPEND, ACT_INSERT_PREV, ACT_INSERT_NEXT:
            start_fail = (free_top_ff == '0);
         ACT_REMOVE_CUR, ACT_REMOVE_FIRST, ACT_REMOVE_LAST:
            start_fail = (count_ff == '0);
         ACT_CURSOR_PREV: start_fail = (cursor_ff == NIL) || (cursor_ff == head_ff);
         ACT_CURSOR_NEXT: start_fail = (cursor_ff == NIL) || (cursor_ff == tail_ff);
         ACT_READ:        start_fail = (cursor_ff == NIL);
         default:         start_fail = 1'b1;
      endcase
      rem_count = count_ff - ONE;
      rem_head  = (rem_count == '0) ? NIL : ((p_ff == NIL) ? q_ff : head_ff);
      rem_tail  = (rem_count == '0) ? NIL : ((q_ff == NIL) ? p_ff : tail_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_chan.valid) state_in = ST_START;
         ST_START: begin
            if (out_free) begin
               if (start_fail)  state_in = ST_IDLE;
               else if (is_ins) state_in = pop_fresh ? ST_LINK : ST_POPWAIT;
               else             state_in = ST_RDWAIT;
            end
         end
         ST_POPWAIT: state_in = ST_LINK;
         ST_LINK: begin
            if (count_ff == '0) state_in = ST_IDLE;
            else if (act_ff == ACT_PREPEND || act_ff == ACT_APPEND) state_in = ST_FIX;
            else state_in = ST_RDWAIT;
         end
         ST_RDWAIT:  state_in = ST_APPLY;
         ST_APPLY: begin
            if (act_ff == ACT_INSERT_PREV || act_ff == ACT_INSERT_NEXT) state_in = ST_FIX;
            else state_in = ST_IDLE;
         end
         ST_FIX:     state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      act_in = act_ff;       din_in = din_ff;       node_in = node_ff;
      p_in = p_ff;           q_in = q_ff;           w_in = w_ff;
      head_in = head_ff;     tail_in = tail_ff;     cursor_in = cursor_ff;
      count_in = count_ff;   free_top_in = free_top_ff; wm_in = wm_ff;
      data_we = 1'b0; next_we = 1'b0; prev_we = 1'b0; free_we = 1'b0;
      data_wa = node_ff[ADDR_W-1:0]; next_wa = node_ff[ADDR_W-1:0];
      prev_wa = node_ff[ADDR_W-1:0]; free_wa = free_top_ff[ADDR_W-1:0];
      data_wd = din_ff; next_wd = NIL; prev_wd = NIL; free_wd = node_ff[ADDR_W-1:0];
      data_ra = '0; next_ra = '0; prev_ra = '0; free_ra = '0;
      fin = 1'b0; fin_data = '0; fin_status = STAT_OK;
      req_chan.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               act_in = req_chan.action;
               din_in = req_chan.data_in;
            end
         end
         ST_START: begin
            if (out_free) begin
               if (start_fail) begin
                  fin = 1'b1;
                  fin_status = is_ins ? STAT_FULL : STAT_EMPTY;
               end else if (is_ins) begin
                  free_top_in = pop_pos;
                  free_ra = pop_pos[ADDR_W-1:0];
                  if (pop_fresh) begin
                     node_in = LAST - pop_pos;
                     wm_in = pop_pos;
                  end
               end else if (is_rem) begin
                  node_in = sel_node;
                  data_ra = sel_node[ADDR_W-1:0];
                  next_ra = sel_node[ADDR_W-1:0];
                  prev_ra = sel_node[ADDR_W-1:0];
               end else begin
                  node_in = cursor_ff;
                  data_ra = cursor_ff[ADDR_W-1:0];
                  next_ra = cursor_ff[ADDR_W-1:0];
                  prev_ra = cursor_ff[ADDR_W-1:0];
               end
            end
         end
         ST_POPWAIT: node_in = IDX_W'(free_rd);
         ST_LINK: begin
            data_we = 1'b1;
            if (count_ff == '0) begin
               next_we = 1'b1;
               prev_we = 1'b1;
               head_in = node_ff; tail_in = node_ff; cursor_in = node_ff;
               count_in = count_ff + ONE;
               fin = 1'b1;
            end else begin
               case (act_ff)
                  ACT_PREPEND: begin
                     next_we = 1'b1; next_wd = head_ff;
                     prev_we = 1'b1; prev_wd = NIL;
                  end
                  ACT_APPEND: begin
                     prev_we = 1'b1; prev_wd = tail_ff;
                     next_we = 1'b1; next_wd = NIL;
                  end
                  default: begin
                     next_ra = cursor_ff[ADDR_W-1:0];
                     prev_ra = cursor_ff[ADDR_W-1:0];
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            p_in = prev_rd;
            q_in = next_rd;
            w_in = data_rd;
         end
         ST_APPLY: begin
            case (act_ff) inside
               ACT_INSERT_PREV: begin
                  prev_we = 1'b1; prev_wd = p_ff;
                  next_we = 1'b1; next_wd = cursor_ff;
               end
               ACT_INSERT_NEXT: begin
                  prev_we = 1'b1; prev_wd = cursor_ff;
                  next_we = 1'b1; next_wd = q_ff;
               end
               ACT_REMOVE_CUR, ACT_REMOVE_FIRST, ACT_REMOVE_LAST: begin
                  next_we = (p_ff != NIL); next_wa = p_ff[ADDR_W-1:0]; next_wd = q_ff;
                  prev_we = (q_ff != NIL); prev_wa = q_ff[ADDR_W-1:0]; prev_wd = p_ff;
                  free_we = 1'b1;
                  free_top_in = free_top_ff + ONE;
                  count_in = rem_count;
                  head_in = rem_head;
                  tail_in = rem_tail;
                  if (rem_count == '0) begin
                     cursor_in = NIL;
                  end else if (act_ff == ACT_REMOVE_CUR) begin
                     cursor_in = (q_ff != NIL) ? q_ff : p_ff;
                  end else if (cursor_ff == node_ff) begin
                     cursor_in = (act_ff == ACT_REMOVE_FIRST) ? rem_head : rem_tail;
                  end
                  fin = 1'b1; fin_data = w_ff;
               end
               ACT_CURSOR_PREV: begin cursor_in = p_ff; fin = 1'b1; end
               ACT_CURSOR_NEXT: begin cursor_in = q_ff; fin = 1'b1; end
               default: begin fin = 1'b1; fin_data = w_ff; end
            endcase
         end
         ST_FIX: begin
            count_in = count_ff + ONE;
            fin = 1'b1;
            case (act_ff)
               ACT_PREPEND: begin
                  prev_we = 1'b1; prev_wa = head_ff[ADDR_W-1:0]; prev_wd = node_ff;
                  head_in = node_ff; cursor_in = node_ff;
               end
               ACT_APPEND: begin
                  next_we = 1'b1; next_wa = tail_ff[ADDR_W-1:0]; next_wd = node_ff;
                  tail_in = node_ff; cursor_in = node_ff;
               end
               ACT_INSERT_PREV: begin
                  next_we = (p_ff != NIL); next_wa = p_ff[ADDR_W-1:0]; next_wd = node_ff;
                  if (p_ff == NIL) head_in = node_ff;
                  prev_we = 1'b1; prev_wa = cursor_ff[ADDR_W-1:0]; prev_wd = node_ff;
               end
               default: begin
                  prev_we = (q_ff != NIL); prev_wa = q_ff[ADDR_W-1:0]; prev_wd = node_ff;
                  if (q_ff == NIL) tail_in = node_ff;
                  next_we = 1'b1; next_wa = cursor_ff[ADDR_W-1:0]; next_wd = node_ff;
               end
            endcase
         end
         default: ;
      endcase

      out_data_in = out_data_ff;
      out_status_in = out_status_ff;
      out_count_in = out_count_ff;
      if (fin) begin
         out_valid_in = 1'b1;
         out_data_in = fin_data;
         out_status_in = fin_status;
         out_count_in = ENTRY_W'(count_in);
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= NIL; tail_ff <= NIL; cursor_ff <= NIL;
         count_ff <= '0;
         free_top_ff <= NIL;
         wm_ff <= NIL;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in; tail_ff <= tail_in; cursor_ff <= cursor_in;
         count_ff <= count_in;
         free_top_ff <= free_top_in;
         wm_ff <= wm_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; din_ff <= din_in; node_ff <= node_in;
      p_ff <= p_in; q_ff <= q_in; w_ff <= w_in;
      out_data_ff <= out_data_in;
      out_status_ff <= out_status_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.data_out    = out_data_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.entry_count = out_count_ff;

   assign pool_total = {1'b0, free_top_ff} + {1'b0, count_ff};
   assign cursor_ok  = ((count_ff == '0) == (cursor_ff == NIL));

`include "cursor_doubly_linked_list_macros.svh"

   `CDLL_ASSERT_NOW(a_count_range, 1'b1, count_ff <= NIL, "count above capacity")
   `CDLL_ASSERT_NOW(a_cursor_null, 1'b1, cursor_ok, "cursor/empty mismatch")
   `CDLL_ASSERT_NOW(a_pool_balance, state_ff == ST_IDLE, pool_total == POOL_SIZE, "node pool leak")
   `CDLL_ASSERT_NEXT(a_accept_start, req_chan.valid && req_chan.ready, state_ff == ST_START, "accepted beat not started")

endmodule

`default_nettype wire

// ===== verif/cursor_doubly_linked_list_test.sv =====
// ----------------------------------------------------------------------------
// Cursor doubly linked list testbench
// Random and directed list actions checked beat by beat against a
// behavioral model of the list with its cursor, node pool and free stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_doubly_linked_list_test;
   import cdll_pkg::*;

   localparam int CAP = CAPACITY_DEF;
   localparam int NIL = CAP;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd10;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

   typedef struct packed {
      logic [31:0]        data_out;
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  entry_count;
   } list_result_type;

   class list_scoreboard;
      logic [31:0] word_mem [CAP];
      int          fwd [CAP];
      int          back [CAP];
      int          free_pool [CAP];
      int          free_top, head, tail, cur, count;
      list_result_type pending [$];
      int          errors;

      function void clear();
         for (int i = 0; i < CAP; i++) free_pool[i] = CAP - 1 - i;
         free_top = CAP; head = NIL; tail = NIL; cur = NIL; count = 0;
         errors = 0;
         pending.delete();
      endfunction

      function void unlink(int n);
         int p, q;
         p = back[n]; q = fwd[n];
         if (p != NIL) fwd[p] = q; else head = q;
         if (q != NIL) back[q] = p; else tail = p;
         free_pool[free_top] = n; free_top++;
         count--;
         if (count == 0) begin
            head = NIL; tail = NIL;
         end
      endfunction

      function void note_action(logic [ACTION_W-1:0] act, logic [31:0] din);
         list_result_type r;
         int n, p, q;
         r = '0;
         if (act <= ACT_INSERT_NEXT) begin
            if (free_top == 0) r.status = STAT_FULL;
            else begin
               free_top--;
               n = free_pool[free_top];
               word_mem[n] = din; fwd[n] = NIL; back[n] = NIL;
               if (count == 0) begin
                  head = n; tail = n; cur = n;
               end else if (act == ACT_PREPEND) begin
                  fwd[n] = head; back[head] = n; head = n; cur = n;
               end else if (act == ACT_APPEND) begin
                  back[n] = tail; fwd[tail] = n; tail = n; cur = n;
               end else if (act == ACT_INSERT_PREV) begin
                  p = back[cur];
                  back[n] = p; fwd[n] = cur;
                  if (p != NIL) fwd[p] = n; else head = n;
                  back[cur] = n;
               end else begin
                  q = fwd[cur];
                  back[n] = cur; fwd[n] = q;
                  if (q != NIL) back[q] = n; else tail = n;
                  fwd[cur] = n;
               end
               count++;
            end
         end else if (act <= ACT_REMOVE_LAST) begin
            if (count == 0) r.status = STAT_EMPTY;
            else begin
               n = (act == ACT_REMOVE_CUR) ? cur :
                   (act == ACT_REMOVE_FIRST) ? head : tail;
               p = back[n]; q = fwd[n];
               r.data_out = word_mem[n];
               unlink(n);
               if (act == ACT_REMOVE_CUR) cur = (q != NIL) ? q : p;
               else if (cur == n) cur = (act == ACT_REMOVE_FIRST) ? head : tail;
               if (count == 0) cur = NIL;
            end
         end else if (act == ACT_CURSOR_PREV) begin
            if (cur == NIL || cur == head) r.status = STAT_EMPTY;
            else cur = back[cur];
         end else if (act == ACT_CURSOR_NEXT) begin
            if (cur == NIL || cur == tail) r.status = STAT_EMPTY;
            else cur = fwd[cur];
         end else if (act == ACT_READ) begin
            if (cur == NIL) r.status = STAT_EMPTY;
            else r.data_out = word_mem[cur];
         end else r.status = STAT_EMPTY;
         r.entry_count = ENTRY_W'(count);
         pending.push_back(r);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
         errors++;
      endtask

      task check_result(list_result_type got);
         list_result_type want;
         if (pending.size() == 0) begin
            report("unexpected beat", got.data_out, 32'd0);
            return;
         end
         want = pending.pop_front();
         if (got.data_out !== want.data_out) report("data_out", got.data_out, want.data_out);
         if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
         if (got.entry_count !== want.entry_count)
            report("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   cdll_req_if req_chan ();
   cdll_rsp_if rsp_chan ();

   cursor_doubly_linked_list dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   list_scoreboard board = new();
   bit stimulus_done = 0;

   initial begin
      req_chan.valid = 0; req_chan.action = '0; req_chan.data_in = '0;
      rsp_chan.ready = 0;
   end

   function int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_action(logic [ACTION_W-1:0] act, logic [31:0] din);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_chan.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= act;
      req_chan.data_in <= din;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_action(act, din);
   endtask

   task automatic send_random(int n, int insert_weight);
      logic [ACTION_W-1:0] a;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < insert_weight)
            a = ACTION_W'($urandom_range(ACT_PREPEND, ACT_INSERT_NEXT));
         else if ($urandom_range(0, 19) == 0)
            a = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
         else
            a = ACTION_W'($urandom_range(ACT_REMOVE_CUR, ACT_READ));
         send_action(a, $urandom());
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_result({rsp_chan.data_out, rsp_chan.status, rsp_chan.entry_count});
         rsp_chan.ready <= ($urandom_range(0, 99) < 10) ? 1'b0 :
                           (($urandom_range(0, 99) < 3) ? 1'b0 : 1'b1);
      end
   end

   initial begin
      board.clear();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // empty list corner cases, then directed actions on a short list
      send_action(ACT_REMOVE_CUR, 0);
      send_action(ACT_REMOVE_FIRST, 0);
      send_action(ACT_REMOVE_LAST, 0);
      send_action(ACT_CURSOR_PREV, 0);
      send_action(ACT_CURSOR_NEXT, 0);
      send_action(ACT_READ, 0);
      send_action(ACT_UNUSED_HI, 32'hffff_ffff);
      send_action(ACT_INSERT_PREV, 32'hffff_ffff);
      send_action(ACT_PREPEND, 32'h0);
      send_action(ACT_APPEND, 32'h8000_0001);
      send_action(ACT_INSERT_NEXT, 32'h5555_aaaa);
      send_action(ACT_CURSOR_PREV, 0);
      send_action(ACT_READ, 0);
      send_action(ACT_CURSOR_NEXT, 0);
      send_action(ACT_CURSOR_NEXT, 0);
      send_action(ACT_REMOVE_CUR, 0);
      send_action(ACT_REMOVE_FIRST, 0);
      send_action(ACT_REMOVE_LAST, 0);
      send_action(ACT_REMOVE_CUR, 0);
      send_action(ACT_UNUSED_LO, 0);
      // fill past capacity, then drain
      send_random(170, 95);
      send_random(110, 100);
      send_action(ACT_APPEND, $urandom());
      send_random(80, 5);
      send_random(90, 50);
      req_chan.valid <= 1'b0;
      stimulus_done = 1;
   end

   initial begin
      wait (stimulus_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/cdll_pkg.sv
hw/rtl/cdll_req_if.sv
hw/rtl/cdll_rsp_if.sv
hw/rtl/cdll_ram.sv
hw/rtl/cursor_doubly_linked_list.sv
verif/cursor_doubly_linked_list_test.sv
